>>> rtl/tlgs_pkg.sv
// Shared types and codes for the two-local gate sequencer.
`default_nettype none

package tlgs_pkg;

  // Gate codes on the result channel
  typedef enum logic [2:0] {
    OP_RY  = 3'd0,
    OP_RX  = 3'd1,
    OP_RZ  = 3'd2,
    OP_CX  = 3'd3,
    OP_CZ  = 3'd4,
    OP_CRX = 3'd5
  } op_t;

  // Entangling patterns
  typedef enum logic [2:0] {
    PAT_FULL     = 3'd0,
    PAT_LINEAR   = 3'd1,
    PAT_CIRCULAR = 3'd2,
    PAT_PAIRWISE = 3'd3,
    PAT_DOUBLE   = 3'd4,
    PAT_SHIFTED  = 3'd5
  } pat_t;

  // Entangler codes
  localparam logic [1:0] ENT_CX  = 2'd0;
  localparam logic [1:0] ENT_CZ  = 2'd1;
  localparam logic [1:0] ENT_CRX = 2'd2;

  // Register word indexes
  localparam logic [2:0] REG_QUBITS  = 3'd0;
  localparam logic [2:0] REG_LAYERS  = 3'd1;
  localparam logic [2:0] REG_ROT     = 3'd2;
  localparam logic [2:0] REG_ENT     = 3'd3;
  localparam logic [2:0] REG_PATTERN = 3'd4;

  localparam int CUR_W   = 6;   // cursors reach the qubit count itself
  localparam int LAYER_W = 10;
  localparam int PIDX_W  = 18;

  // Walk state through the circuit
  typedef struct packed {
    logic               link;   // in an entangling layer
    logic [LAYER_W-1:0] layer;  // entangling layers completed
    logic [CUR_W-1:0]   lmod;   // layer mod qubit count
    logic [CUR_W-1:0]   fc;     // first cursor
    logic [CUR_W-1:0]   sc;     // second cursor
    logic               sr;     // second rotation pending/at work
    logic               odd;    // odd-start pass of double pairwise
    logic [PIDX_W-1:0]  pc;     // running parameter index
  } walk_t;

endpackage

`default_nettype wire

>>> rtl/two_local_gate_sequencer.sv
// Two-local circuit gate sequencer: one gate descriptor per advance request.
`default_nettype none

// Walks a two-local circuit (rotation layer, then layer_count rounds of an
// entangling layer plus a rotation layer) and returns one gate descriptor for
// every request on the input channel. A request with restart set begins the
// circuit again at its first gate; otherwise it advances. Empty entangling
// layers are skipped without a gate, and after the gate flagged last the walk
// wraps to the start. Angle-taking gates carry a running parameter index that
// starts at 0 for each circuit. Throughput is one request per clock cycle
// while out_stall does not hold the result: the whole step (pattern
// selection, cursor advance, layer skip) is one short combinational pass
// from the request register into the result register, which loads the
// result once it is free. The request register and the result
// register each hold one entry, so one request can be taken while a result
// waits on out_stall. Any register write rewinds the walk and clears the
// parameter index; write registers only while idle.
// Qubit counts below 2 act as 2, above MAX_QUBITS as MAX_QUBITS; layer counts
// above MAX_LAYERS act as MAX_LAYERS; entangler code 3 acts as CX and pattern
// codes 6 and 7 act as full.
module two_local_gate_sequencer #(
  parameter int MAX_QUBITS = 16,
  parameter int MAX_LAYERS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  gate_op,
  output logic [3:0]  qubit_a,
  output logic [3:0]  qubit_b,
  output logic [17:0] param_index,
  output logic        uses_param,
  output logic        last
);
  import tlgs_pkg::*;

  // Count registers can only hold 31 qubits / 1023 layers.
  localparam int QCAP = (MAX_QUBITS > 31) ? 31 : MAX_QUBITS;
  localparam int LCAP = (MAX_LAYERS > 1023) ? 1023 : MAX_LAYERS;

  // configuration registers
  logic [4:0] qubit_count;
  logic [9:0] layer_count;
  logic [1:0] rotation_mode;
  logic [1:0] entangler_gate;
  logic [2:0] entangle_pattern;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       cfg_hit;

  // request register, walk state, result register
  logic       in_full;
  logic       in_restart;
  walk_t      st;
  walk_t      st_next;
  logic       out_free;
  logic       fire;

  // effective settings
  logic [CUR_W-1:0]   n_eff;
  logic [LAYER_W-1:0] layers_eff;
  pat_t               pat;
  op_t                ent_op;

  // step results
  op_t                op_next;
  logic [CUR_W-1:0]   qa_next;
  logic [CUR_W-1:0]   qb_next;
  logic [PIDX_W-1:0]  pidx_next;
  logic               uses_next;
  logic               last_next;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];
  assign cfg_hit = cfg_wr && (cfg_idx <= REG_PATTERN);

  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count      <= 5'd2;
      layer_count      <= 10'd1;
      rotation_mode    <= '0;
      entangler_gate   <= ENT_CX;
      entangle_pattern <= PAT_FULL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_QUBITS:  qubit_count      <= pwdata[4:0];
        REG_LAYERS:  layer_count      <= pwdata[9:0];
        REG_ROT:     rotation_mode    <= pwdata[1:0];
        REG_ENT:     entangler_gate   <= pwdata[1:0];
        REG_PATTERN: entangle_pattern <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_QUBITS:  prdata = {27'd0, qubit_count};
      REG_LAYERS:  prdata = {22'd0, layer_count};
      REG_ROT:     prdata = {30'd0, rotation_mode};
      REG_ENT:     prdata = {30'd0, entangler_gate};
      REG_PATTERN: prdata = {29'd0, entangle_pattern};
      default:     prdata = '0;
    endcase
  end

  // Clamp settings.
  always_comb begin
    if (qubit_count < 5'd2) begin
      n_eff = CUR_W'(2);
    end else if (qubit_count > 5'(QCAP)) begin
      n_eff = CUR_W'(QCAP);
    end else begin
      n_eff = CUR_W'(qubit_count);
    end
    layers_eff = (layer_count > 10'(LCAP)) ? 10'(LCAP) : layer_count;
    pat        = (entangle_pattern > 3'(PAT_SHIFTED)) ? PAT_FULL : pat_t'(entangle_pattern);
    unique case (entangler_gate)
      ENT_CZ:  ent_op = OP_CZ;
      ENT_CRX: ent_op = OP_CRX;
      default: ent_op = OP_CX;
    endcase
  end

  // Does the entangling layer still have a gate at cursor f?
  function automatic logic link_ok(pat_t p, logic [CUR_W-1:0] n, logic [CUR_W-1:0] f);
    logic r;
    if (p == PAT_CIRCULAR || p == PAT_SHIFTED) begin
      r = f < n;
    end else begin
      r = ({1'b0, f} + 1'b1) < {1'b0, n};
    end
    return r;
  endfunction

  // Close an entangling layer and open the next rotation layer.
  function automatic walk_t end_link(walk_t x, logic [CUR_W-1:0] n);
    walk_t   y;
    logic [CUR_W-1:0] lm_inc;
    y      = x;
    lm_inc = x.lmod + 1'b1;
    y.layer = x.layer + 1'b1;
    y.lmod  = (lm_inc == n) ? '0 : lm_inc;
    y.link  = 1'b0;
    y.fc    = '0;
    y.sr    = 1'b0;
    return y;
  endfunction

  // One step of the walk.
  always_comb begin
    walk_t            s;
    logic [CUR_W-1:0] fc_inc;
    logic [CUR_W:0]   diff;
    s         = in_restart ? '0 : st;
    st_next   = s;
    op_next   = OP_RY;
    qa_next   = s.fc;
    qb_next   = '0;
    pidx_next = '0;
    uses_next = 1'b0;
    last_next = 1'b0;
    fc_inc    = s.fc + 1'b1;
    diff      = {1'b0, s.fc} - {1'b0, s.lmod};

    if (!s.link) begin
      // rotation gate
      op_next    = s.sr ? OP_RZ : (rotation_mode[0] ? OP_RX : OP_RY);
      uses_next  = 1'b1;
      pidx_next  = s.pc;
      st_next.pc = s.pc + 1'b1;
      if (rotation_mode[1] && !s.sr) begin
        st_next.sr = 1'b1;
      end else begin
        st_next.sr = 1'b0;
        st_next.fc = fc_inc;
        if (fc_inc >= n_eff) begin
          if (s.layer >= layers_eff) begin
            last_next = 1'b1;
            st_next   = '0;
          end else begin
            // open the entangling layer
            st_next.link = 1'b1;
            st_next.odd  = (pat == PAT_PAIRWISE) ? s.layer[0] : (pat == PAT_DOUBLE);
            st_next.fc   = CUR_W'(st_next.odd);
            st_next.sc   = CUR_W'(st_next.odd) + 1'b1;
            if (pat == PAT_DOUBLE && !link_ok(pat, n_eff, st_next.fc)) begin
              st_next.odd = 1'b0;
              st_next.fc  = '0;
              st_next.sc  = CUR_W'(1);
            end
            if (!link_ok(pat, n_eff, st_next.fc)) begin
              st_next = end_link(st_next, n_eff);
            end
          end
        end
      end
    end else begin
      // entangling gate
      op_next = ent_op;
      unique case (pat)
        PAT_FULL: begin
          qb_next = s.sc;
        end
        PAT_CIRCULAR: begin
          qb_next = (fc_inc >= n_eff) ? '0 : fc_inc;
        end
        PAT_SHIFTED: begin
          qa_next = diff[CUR_W] ? (diff[CUR_W-1:0] + n_eff) : diff[CUR_W-1:0];
          qb_next = (qa_next == '0) ? (n_eff - 1'b1) : (qa_next - 1'b1);
        end
        default: begin
          qb_next = fc_inc;
        end
      endcase
      if (entangler_gate == ENT_CRX) begin
        uses_next  = 1'b1;
        pidx_next  = s.pc;
        st_next.pc = s.pc + 1'b1;
      end
      // advance the cursors
      unique case (pat)
        PAT_FULL: begin
          st_next.sc = s.sc + 1'b1;
          if (st_next.sc >= n_eff) begin
            st_next.fc = fc_inc;
            st_next.sc = fc_inc + 1'b1;
          end
        end
        PAT_PAIRWISE: begin
          st_next.fc = s.fc + CUR_W'(2);
        end
        PAT_DOUBLE: begin
          st_next.fc = s.fc + CUR_W'(2);
          if (s.odd && ({1'b0, st_next.fc} + 1'b1) >= {1'b0, n_eff}) begin
            st_next.odd = 1'b0;
            st_next.fc  = '0;
          end
        end
        default: begin
          st_next.fc = fc_inc;
        end
      endcase
      if (!link_ok(pat, n_eff, st_next.fc)) begin
        st_next = end_link(st_next, n_eff);
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign fire     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_hit) begin
        st <= '0;
      end else if (fire) begin
        st <= st_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_restart <= restart;
    end
    if (fire) begin
      gate_op     <= op_next;
      qubit_a     <= qa_next[3:0];
      qubit_b     <= qb_next[3:0];
      param_index <= pidx_next;
      uses_param  <= uses_next;
      last        <= last_next;
    end
  end

  // The final gate of a circuit is always a rotation.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (uses_param && (gate_op == OP_RY || gate_op == OP_RX ||
                                            gate_op == OP_RZ)))
    else $error("last flag on a non-rotation gate");

  // Single-qubit gates carry no second qubit.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (gate_op == OP_RY || gate_op == OP_RX || gate_op == OP_RZ)) |->
      (qubit_b == 4'd0))
    else $error("rotation gate with nonzero second qubit");

  // Issuing the final gate rewinds the walk.
  assert property (@(posedge clk) disable iff (rst)
    (fire && last_next && !cfg_hit) |=> (st.pc == '0 && !st.link && st.layer == '0))
    else $error("walk not rewound after final gate");

  // The completed layer count never passes the configured count.
  assert property (@(posedge clk) disable iff (rst)
    st.layer <= layers_eff)
    else $error("layer index beyond layer count");

endmodule

`default_nettype wire
